/* hdl/dns_name_decompressor_assert.svh */
// Assertion macros for the DNS name decompressor.
`ifndef DNS_NAME_DECOMPRESSOR_ASSERT_SVH
`define DNS_NAME_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DNSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dnsd assertion failed");

// Next-cycle implication, checked outside reset.
`define DNSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dnsd assertion failed");

`endif

/* hdl/dnsd_pkg.sv */
// Shared types and constants of the DNS name decompressor.
package dnsd_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OFFSET     = 3'd1,
        ST_TRUNC_PTR  = 3'd2,
        ST_JUMPS      = 3'd3,
        ST_FWD_PTR    = 3'd4,
        ST_LABEL_LONG = 3'd5,
        ST_LABEL_PAST = 3'd6,
        ST_NAME_LONG  = 3'd7
    } t_status;

    localparam logic       OP_LOAD    = 1'b0;
    localparam logic       OP_EXTRACT = 1'b1;

    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [1:0] PTR_TAG    = 2'b11;
    localparam logic [3:0] JUMP_RESET = 4'd10;

    localparam int NAME_STORE_DEPTH = 256;
    localparam int NAME_AW          = 8;
    localparam int CHUNK_BYTES      = 8;

endpackage

/* hdl/dns_name_decompressor.sv */
// DNS name decompressor: packet byte store, name walker and chunked name output.
//
// Input channel (i_valid / o_ready): each beat is either a load, which appends
// i_byte_value to the packet store, or an extract, which walks the DNS name at
// i_start_offset and then clears the loaded byte count. Bytes beyond
// PACKET_DEPTH are dropped. The block stays idle after a load, so loads stream back to
// back. An extract occupies the block until its last result beat is taken.
// Walk: S_RD/S_BYTE per label or pointer byte, S_COPY per label character, S_PTR
// per pointer target (one packet RAM port, registered read).
// Output channel (o_valid / i_ready): one beat per 8-character chunk, lowest
// byte first, o_last on the final one; an empty name gives one beat of length
// 0; an error gives one beat with the status. Each chunk is gathered from the
// name RAM one byte per cycle, then held until taken.
// While the receiver stalls, the block simply waits with its result.
// i_cfg_we writes jump_limit at once. Reset (synchronous, active low) empties
// the packet store count, sets jump_limit to 10 and returns to idle.
`include "dns_name_decompressor_assert.svh"

module dns_name_decompressor #(
    parameter int PACKET_DEPTH = 512,
    parameter int NAME_LIMIT   = 255,
    parameter int LABEL_LIMIT  = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_byte_value,
    input  logic [9:0]  i_start_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_name_chunk,
    output logic [3:0]  o_chunk_length,
    output logic [2:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);

    localparam int PAW  = $clog2(PACKET_DEPTH);
    localparam int CW   = $clog2(PACKET_DEPTH + 1);
    localparam int CMPW = ((CW > 14) ? CW : 14) + 1;
    localparam int NAW  = dnsd_pkg::NAME_AW;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RD, S_BYTE, S_PTR, S_COPY, S_NEXT, S_GATH, S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pos, n_pos;
    logic [9:0]         r_start, n_start;
    logic [4:0]         r_jumps, n_jumps;
    logic [3:0]         r_jump_limit;
    logic [5:0]         r_ptr_hi, n_ptr_hi;
    logic [5:0]         r_rem, n_rem;
    logic [NAW-1:0]     r_len, n_len;
    logic [NAW-1:0]     r_done, n_done;
    logic               r_wpend, n_wpend;
    logic               r_npend, n_npend;
    logic [2:0]         r_nslot, n_nslot;
    logic [3:0]         r_k, n_k;
    logic [3:0]         r_cnt, n_cnt;
    logic [63:0]        r_chunk, n_chunk;
    dnsd_pkg::t_status  r_status, n_status;
    logic               r_last, n_last;
    logic               r_valid, n_valid;

    logic               pkt_we;
    logic [PAW-1:0]     pkt_raddr;
    logic [7:0]         pkt_rdata;
    logic               name_we;
    logic [NAW-1:0]     name_raddr;
    logic [7:0]         name_wdata;
    logic [7:0]         name_rdata;
    logic               dot_we;

    logic               c_err;
    dnsd_pkg::t_status  c_err_code;
    logic               c_ok;
    logic [CW-1:0]      c_pos_inc;
    logic [CMPW-1:0]    c_pos_x, c_cnt_x, c_start_x, c_target_x, c_lab_end;
    logic [4:0]         c_jumps_inc;
    logic [9:0]         c_newlen;
    logic [NAW-1:0]     c_left;
    logic [NAW:0]       c_done_end;

    assign c_pos_inc   = r_pos + CW'(1);
    assign c_pos_x     = CMPW'(r_pos);
    assign c_cnt_x     = CMPW'(r_count);
    assign c_start_x   = CMPW'(r_start);
    assign c_target_x  = CMPW'({r_ptr_hi, pkt_rdata});
    assign c_lab_end   = c_pos_x + CMPW'(1) + CMPW'(pkt_rdata);
    assign c_jumps_inc = r_jumps + 5'd1;
    assign c_newlen    = 10'(r_len) + 10'(r_len != '0) + 10'(pkt_rdata);
    assign c_left      = r_len - r_done;
    assign c_done_end  = (NAW+1)'(r_done) + (NAW+1)'(r_cnt);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_start    = r_start;
        n_jumps    = r_jumps;
        n_ptr_hi   = r_ptr_hi;
        n_rem      = r_rem;
        n_len      = r_len;
        n_done     = r_done;
        n_wpend    = 1'b0;
        n_npend    = 1'b0;
        n_nslot    = r_nslot;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_chunk    = r_chunk;
        n_status   = r_status;
        n_last     = r_last;
        n_valid    = r_valid;
        pkt_we     = 1'b0;
        dot_we     = 1'b0;
        c_err      = 1'b0;
        c_err_code = dnsd_pkg::ST_OK;
        c_ok       = 1'b0;

        // a character read last cycle lands in the name store now
        if (r_wpend) begin
            n_len = r_len + NAW'(1);
        end
        // a name byte read last cycle lands in its chunk lane now
        for (int i = 0; i < dnsd_pkg::CHUNK_BYTES; i++) begin
            if (r_npend && r_nslot == 3'(i)) begin
                n_chunk[8*i +: 8] = name_rdata;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == dnsd_pkg::OP_LOAD) begin
                        if (r_count < CW'(PACKET_DEPTH)) begin
                            pkt_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_start = i_start_offset;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (c_start_x > c_cnt_x) begin
                    c_err      = 1'b1;
                    c_err_code = dnsd_pkg::ST_OFFSET;
                end else begin
                    n_pos   = c_start_x[CW-1:0];
                    n_jumps = '0;
                    n_len   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_pos >= r_count) begin
                    c_ok = 1'b1;
                end else begin
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (pkt_rdata == 8'd0) begin
                    c_ok = 1'b1;
                end else if (pkt_rdata[7:6] == dnsd_pkg::PTR_TAG) begin
                    if (c_pos_inc >= r_count) begin
                        c_err      = 1'b1;
                        c_err_code = dnsd_pkg::ST_TRUNC_PTR;
                    end else if (c_jumps_inc > {1'b0, r_jump_limit}) begin
                        c_err      = 1'b1;
                        c_err_code = dnsd_pkg::ST_JUMPS;
                    end else begin
                        n_jumps  = c_jumps_inc;
                        n_ptr_hi = pkt_rdata[5:0];
                        n_state  = S_PTR;
                    end
                end else if (pkt_rdata > 8'(LABEL_LIMIT)) begin
                    c_err      = 1'b1;
                    c_err_code = dnsd_pkg::ST_LABEL_LONG;
                end else if (c_lab_end > c_cnt_x) begin
                    c_err      = 1'b1;
                    c_err_code = dnsd_pkg::ST_LABEL_PAST;
                end else if (c_newlen > 10'(NAME_LIMIT)) begin
                    c_err      = 1'b1;
                    c_err_code = dnsd_pkg::ST_NAME_LONG;
                end else begin
                    if (r_len != '0) begin
                        dot_we = 1'b1;
                        n_len  = r_len + NAW'(1);
                    end
                    n_pos   = c_pos_inc;
                    n_rem   = pkt_rdata[5:0];
                    n_state = S_COPY;
                end
            end
            S_PTR: begin
                if (c_target_x >= c_pos_x) begin
                    c_err      = 1'b1;
                    c_err_code = dnsd_pkg::ST_FWD_PTR;
                end else begin
                    n_pos   = c_target_x[CW-1:0];
                    n_state = S_RD;
                end
            end
            S_COPY: begin
                n_wpend = 1'b1;
                n_pos   = c_pos_inc;
                n_rem   = r_rem - 6'd1;
                if (r_rem == 6'd1) begin
                    n_state = S_RD;
                end
            end
            S_NEXT: begin
                n_cnt   = (c_left > NAW'(dnsd_pkg::CHUNK_BYTES)) ?
                          4'(dnsd_pkg::CHUNK_BYTES) : c_left[3:0];
                n_k     = '0;
                n_chunk = '0;
                n_state = S_GATH;
            end
            S_GATH: begin
                if (r_k != r_cnt) begin
                    n_npend = 1'b1;
                    n_nslot = r_k[2:0];
                    n_k     = r_k + 4'd1;
                end else if (!r_npend) begin
                    n_status = dnsd_pkg::ST_OK;
                    n_last   = (c_done_end >= (NAW+1)'(r_len));
                    n_valid  = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    n_done  = c_done_end[NAW-1:0];
                    n_state = r_last ? S_IDLE : S_NEXT;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (c_err) begin
            n_chunk  = '0;
            n_cnt    = '0;
            n_status = c_err_code;
            n_last   = 1'b1;
            n_valid  = 1'b1;
            n_len    = '0;
            n_count  = '0;
            n_state  = S_OUT;
        end
        if (c_ok) begin
            n_done  = '0;
            n_count = '0;
            n_state = S_NEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_len        <= '0;
            r_wpend      <= 1'b0;
            r_npend      <= 1'b0;
            r_valid      <= 1'b0;
            r_jump_limit <= dnsd_pkg::JUMP_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_len   <= n_len;
            r_wpend <= n_wpend;
            r_npend <= n_npend;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_jump_limit <= i_cfg_data;
            end
        end
        r_pos    <= n_pos;
        r_start  <= n_start;
        r_jumps  <= n_jumps;
        r_ptr_hi <= n_ptr_hi;
        r_rem    <= n_rem;
        r_done   <= n_done;
        r_nslot  <= n_nslot;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_chunk  <= n_chunk;
        r_status <= n_status;
        r_last   <= n_last;
    end

    // pointer low byte sits right after the tag byte
    assign pkt_raddr = (r_state == S_BYTE) ? c_pos_inc[PAW-1:0] : r_pos[PAW-1:0];

    dnsd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_DEPTH)
    ) u_packet_ram (
        .i_clk   (i_clk),
        .i_we    (pkt_we),
        .i_waddr (r_count[PAW-1:0]),
        .i_wdata (i_byte_value),
        .i_raddr (pkt_raddr),
        .o_rdata (pkt_rdata)
    );

    assign name_we    = dot_we | r_wpend;
    assign name_wdata = r_wpend ? pkt_rdata : dnsd_pkg::DOT_CHAR;
    assign name_raddr = r_done + NAW'(r_k);

    dnsd_ram #(
        .WIDTH (8),
        .DEPTH (dnsd_pkg::NAME_STORE_DEPTH)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (r_len),
        .i_wdata (name_wdata),
        .i_raddr (name_raddr),
        .o_rdata (name_rdata)
    );

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_valid;
    assign o_name_chunk   = r_chunk;
    assign o_chunk_length = r_cnt;
    assign o_status       = r_status;
    assign o_last         = r_last;

    `DNSD_ASSERT_NOW(a_no_accept_while_result, i_clk, i_rst_n, o_ready, !o_valid)
    `DNSD_ASSERT_NEXT(a_extract_blocks_input, i_clk, i_rst_n,
        i_valid && o_ready && i_operation == dnsd_pkg::OP_EXTRACT, !o_ready)
    `DNSD_ASSERT_NOW(a_error_beat_empty, i_clk, i_rst_n,
        o_valid && o_status != dnsd_pkg::ST_OK, o_last && o_chunk_length == 4'd0)
    `DNSD_ASSERT_NOW(a_inner_chunk_full, i_clk, i_rst_n,
        o_valid && !o_last, o_chunk_length == 4'd8)

endmodule

/* hdl/dnsd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dnsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
